// ----- rtl/density_clustering_2d_core_assert.svh -----
// assertion macros for the clustering core controller
// depends on nothing; included by dc2d_ctrl
`ifndef DENSITY_CLUSTERING_2D_CORE_ASSERT_SVH
`define DENSITY_CLUSTERING_2D_CORE_ASSERT_SVH
`define DC_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define DC_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/dc2d_pkg.sv -----
// package for the clustering core: constants, payload types, states, commands
// depends on nothing
package dc2d_pkg;
    localparam int MaxPoints = 64;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int LabelW = 7;
    localparam int EpsW = 26;
    localparam int MinW = 7;
    localparam int CfgW = 26;
    localparam logic CfgEps = 1'b0;
    localparam logic CfgMin = 1'b1;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        final_point;
    } in_item_t;

    typedef struct packed {
        logic [IdxW-1:0]   point_index;
        logic [LabelW-1:0] cluster_label;
        logic              end_of_labels;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD, ST_CLEAR, ST_OUTER, ST_CNT_I, ST_CNT_I_END, ST_PUSH, ST_PUSH_END,
        ST_POP, ST_POP_WAIT, ST_CNT_Q, ST_CNT_Q_END, ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic load_pt;
        logic scan_start;
        logic scan_step;
        logic cnt_en;
        logic push_en;
        logic new_cluster;
        logic seed_i;
        logic pop;
        logic take_q;
        logic next_i;
        logic emit_start;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic is_core;
        logic i_done;
        logic i_visited;
        logic q_empty;
        logic q_visited;
        logic emit_last;
        logic full;
    } stat_t;
endpackage

// ----- rtl/dc2d_ram.sv -----
// generic single write, single registered read ram
// depends on nothing
module dc2d_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/dc2d_datapath.sv -----
// datapath: point stores, neighbor test pipeline, marks, labels, queue
// depends on dc2d_pkg and dc2d_ram
module dc2d_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dc2d_pkg::cmd_t         cmd,
    output dc2d_pkg::stat_t        stat,
    input  dc2d_pkg::in_item_t     s_item,
    input  logic [dc2d_pkg::EpsW-1:0] eps_reg_in,
    input  logic [dc2d_pkg::MinW-1:0] min_reg_in,
    output dc2d_pkg::out_item_t    m_item
);
    localparam int IW = dc2d_pkg::IdxW;
    localparam int CW = dc2d_pkg::CntW;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg;
    logic [IW-1:0] p_reg;
    logic [CW-1:0] q_reg;
    logic [IW-1:0] q_d1_reg, q_d2_reg, q_d3_reg;
    logic          v_d1_reg, v_d2_reg, v_d3_reg;
    logic          start_d1_reg;
    logic [15:0]   px_reg, py_reg;
    logic [11:0]   dx_reg, dy_reg;
    logic [24:0]   dd_reg;
    logic [CW-1:0] nbr_reg;
    logic [dc2d_pkg::MaxPoints-1:0] visited_reg, queued_reg, labeled_reg;
    logic [dc2d_pkg::LabelW-1:0] cluster_reg;
    logic [CW-1:0] head_reg, tail_reg;
    logic [15:0]   xr, yr;
    logic [IW-1:0] qr;
    logic [IW-1:0] raddr;
    logic [16:0]   ddx, ddy;
    logic          hit;
    logic          qwe;
    logic          lwe;
    logic [IW-1:0] lwaddr, lraddr;
    logic [dc2d_pkg::LabelW-1:0] lwdata, lr;

    assign count_next = count_reg + CW'(1);
    assign raddr = cmd.scan_start ? p_reg : q_reg[IW-1:0];
    assign stat.full = (count_reg == CW'(dc2d_pkg::MaxPoints));

    dc2d_ram #(.Width(16), .Depth(dc2d_pkg::MaxPoints)) u_x (
        .aclk(aclk), .we(cmd.load_pt && !stat.full), .waddr(count_reg[IW-1:0]),
        .wdata(s_item.pos_x), .raddr(raddr), .rdata(xr));
    dc2d_ram #(.Width(16), .Depth(dc2d_pkg::MaxPoints)) u_y (
        .aclk(aclk), .we(cmd.load_pt && !stat.full), .waddr(count_reg[IW-1:0]),
        .wdata(s_item.pos_y), .raddr(raddr), .rdata(yr));
    assign qwe = cmd.push_en && v_d3_reg && hit && !queued_reg[q_d3_reg]
                 && tail_reg < CW'(dc2d_pkg::MaxPoints);
    dc2d_ram #(.Width(IW), .Depth(dc2d_pkg::MaxPoints)) u_q (
        .aclk(aclk), .we(qwe), .waddr(tail_reg[IW-1:0]), .wdata(q_d3_reg),
        .raddr(head_reg[IW-1:0]), .rdata(qr));

    // label store, unlabeled entries read as noise
    assign lwe = cmd.new_cluster || (cmd.take_q && !labeled_reg[qr]);
    assign lwaddr = cmd.new_cluster ? i_reg[IW-1:0] : qr;
    assign lwdata = cmd.new_cluster ? cluster_reg + dc2d_pkg::LabelW'(1) : cluster_reg;
    assign lraddr = cmd.emit_step ? q_reg[IW-1:0] + IW'(1) : q_reg[IW-1:0];
    dc2d_ram #(.Width(dc2d_pkg::LabelW), .Depth(dc2d_pkg::MaxPoints)) u_l (
        .aclk(aclk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
        .raddr(lraddr), .rdata(lr));

    // stage 1 abs diff, stage 2 square sum
    always_comb begin
        ddx = (px_reg >= xr) ? {1'b0, px_reg - xr} : {1'b0, xr - px_reg};
        ddy = (py_reg >= yr) ? {1'b0, py_reg - yr} : {1'b0, yr - py_reg};
        hit = (dd_reg != 25'd0) && ({1'b0, dd_reg} <= eps_reg_in);
    end

    assign stat.scan_last = !v_d1_reg && !v_d2_reg && !v_d3_reg && (q_reg >= count_reg);
    assign stat.is_core = {1'b0, nbr_reg} >= {1'b0, min_reg_in[CW-1:0]}
                          && min_reg_in <= dc2d_pkg::MinW'(dc2d_pkg::MaxPoints)
                          || min_reg_in == '0;
    assign stat.i_done = (i_reg >= count_reg);
    assign stat.i_visited = visited_reg[i_reg[IW-1:0]];
    assign stat.q_empty = (head_reg >= tail_reg);
    assign stat.q_visited = visited_reg[qr];
    assign stat.emit_last = (q_reg + CW'(1) >= count_reg);

    always_ff @(posedge aclk) begin
        dx_reg <= ddx[15:4];
        dy_reg <= ddy[15:4];
        dd_reg <= 25'(24'(dx_reg) * 24'(dx_reg)) + 25'(24'(dy_reg) * 24'(dy_reg));
        q_d1_reg <= q_reg[IW-1:0];
        q_d2_reg <= q_d1_reg;
        q_d3_reg <= q_d2_reg;
        if (start_d1_reg) begin
            px_reg <= xr;
            py_reg <= yr;
        end
        if (cmd.emit_step) begin
            m_item.point_index <= q_reg[IW-1:0];
            m_item.cluster_label <= labeled_reg[q_reg[IW-1:0]] ? lr : '0;
            m_item.end_of_labels <= stat.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            i_reg <= '0;
            q_reg <= '0;
            v_d1_reg <= 1'b0;
            v_d2_reg <= 1'b0;
            v_d3_reg <= 1'b0;
            start_d1_reg <= 1'b0;
            nbr_reg <= '0;
            visited_reg <= '0;
            queued_reg <= '0;
            labeled_reg <= '0;
            cluster_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            p_reg <= '0;
        end else begin
            v_d1_reg <= cmd.scan_step && (q_reg < count_reg);
            v_d2_reg <= v_d1_reg;
            v_d3_reg <= v_d2_reg;
            start_d1_reg <= cmd.scan_start;
            if (cmd.load_pt && !stat.full) begin
                count_reg <= count_next;
            end
            if (cmd.clear) begin
                i_reg <= '0;
                visited_reg <= '0;
                queued_reg <= '0;
                labeled_reg <= '0;
                cluster_reg <= '0;
            end
            if (cmd.next_i) begin
                i_reg <= i_reg + CW'(1);
            end
            // point address setup for a scan: read p, then walk q
            if (cmd.seed_i) begin
                p_reg <= i_reg[IW-1:0];
                q_reg <= i_reg;
                visited_reg[i_reg[IW-1:0]] <= 1'b1;
            end
            if (cmd.take_q) begin
                p_reg <= qr;
                q_reg <= {1'b0, qr};
                visited_reg[qr] <= 1'b1;
                labeled_reg[qr] <= 1'b1;
            end
            if (cmd.scan_start) begin
                q_reg <= '0;
                nbr_reg <= '0;
            end else if (cmd.scan_step && q_reg < count_reg) begin
                q_reg <= q_reg + CW'(1);
            end
            if (cmd.cnt_en && v_d3_reg && hit) begin
                nbr_reg <= nbr_reg + CW'(1);
            end
            if (qwe) begin
                queued_reg[q_d3_reg] <= 1'b1;
                tail_reg <= tail_reg + CW'(1);
            end
            if (cmd.new_cluster) begin
                cluster_reg <= cluster_reg + dc2d_pkg::LabelW'(1);
                labeled_reg[i_reg[IW-1:0]] <= 1'b1;
                queued_reg[i_reg[IW-1:0]] <= 1'b1;
                head_reg <= '0;
                tail_reg <= '0;
            end
            if (cmd.pop) begin
                head_reg <= head_reg + CW'(1);
            end
            if (cmd.emit_start) begin
                q_reg <= '0;
            end else if (cmd.emit_step) begin
                q_reg <= q_reg + CW'(1);
                if (stat.emit_last) begin
                    count_reg <= '0;
                end
            end
        end
    end
endmodule

// ----- rtl/dc2d_ctrl.sv -----
// controller state machine sequencing load, scans, queue and label output
// depends on dc2d_pkg and the assertion header
`include "density_clustering_2d_core_assert.svh"
module dc2d_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_final,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  dc2d_pkg::stat_t stat,
    output dc2d_pkg::cmd_t  cmd
);
    dc2d_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic m_valid_reg, m_valid_next;
    logic prime_reg, prime_next;
    logic s_acc, m_free;

    assign s_acc = s_valid && s_ready;
    assign m_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign s_ready = (state_reg == dc2d_pkg::ST_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dc2d_pkg::ST_LOAD;
            ret_reg <= dc2d_pkg::ST_OUTER;
            m_valid_reg <= 1'b0;
            prime_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            m_valid_reg <= m_valid_next;
            prime_reg <= prime_next;
        end
    end

    // scan states: reading p (prime) comes first, then q steps through the stores
    always_comb begin
        state_next = state_reg;
        ret_next = ret_reg;
        prime_next = 1'b0;
        case (state_reg)
            dc2d_pkg::ST_LOAD: if (s_acc && s_final) state_next = dc2d_pkg::ST_CLEAR;
            dc2d_pkg::ST_CLEAR: state_next = dc2d_pkg::ST_OUTER;
            dc2d_pkg::ST_OUTER: begin
                if (stat.i_done) begin
                    state_next = dc2d_pkg::ST_EMIT;
                    prime_next = 1'b1;
                end else if (!stat.i_visited) begin
                    state_next = dc2d_pkg::ST_CNT_I;
                    prime_next = 1'b1;
                end
            end
            dc2d_pkg::ST_CNT_I: if (!prime_reg && stat.scan_last) state_next = dc2d_pkg::ST_CNT_I_END;
            dc2d_pkg::ST_CNT_I_END: begin
                if (stat.is_core) begin
                    state_next = dc2d_pkg::ST_PUSH;
                    prime_next = 1'b1;
                    ret_next = dc2d_pkg::ST_POP;
                end else begin
                    state_next = dc2d_pkg::ST_OUTER;
                end
            end
            dc2d_pkg::ST_PUSH: if (!prime_reg && stat.scan_last) state_next = ret_reg;
            dc2d_pkg::ST_POP: begin
                if (stat.q_empty) state_next = dc2d_pkg::ST_OUTER;
                else state_next = dc2d_pkg::ST_POP_WAIT;
            end
            dc2d_pkg::ST_POP_WAIT: begin
                if (!stat.q_visited) begin
                    state_next = dc2d_pkg::ST_CNT_Q;
                    prime_next = 1'b1;
                end else begin
                    state_next = dc2d_pkg::ST_POP;
                end
            end
            dc2d_pkg::ST_CNT_Q: if (!prime_reg && stat.scan_last) state_next = dc2d_pkg::ST_CNT_Q_END;
            dc2d_pkg::ST_CNT_Q_END: begin
                if (stat.is_core) begin
                    state_next = dc2d_pkg::ST_PUSH;
                    prime_next = 1'b1;
                end else begin
                    state_next = dc2d_pkg::ST_POP;
                end
            end
            dc2d_pkg::ST_EMIT: if (!prime_reg && m_free && stat.emit_last) state_next = dc2d_pkg::ST_LOAD;
            default: state_next = dc2d_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        cmd = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            dc2d_pkg::ST_LOAD: cmd.load_pt = s_acc;
            dc2d_pkg::ST_CLEAR: cmd.clear = 1'b1;
            dc2d_pkg::ST_OUTER: begin
                if (!stat.i_done && !stat.i_visited) cmd.seed_i = 1'b1;
                else if (!stat.i_done) cmd.next_i = 1'b1;
                else cmd.emit_start = 1'b1;
            end
            dc2d_pkg::ST_CNT_I, dc2d_pkg::ST_CNT_Q: begin
                cmd.scan_start = prime_reg;
                cmd.scan_step = !prime_reg;
                cmd.cnt_en = 1'b1;
            end
            dc2d_pkg::ST_CNT_I_END: begin
                if (stat.is_core) begin
                    cmd.new_cluster = 1'b1;
                    cmd.seed_i = 1'b1;
                end
                cmd.next_i = !stat.is_core;
            end
            dc2d_pkg::ST_PUSH: begin
                cmd.scan_start = prime_reg;
                cmd.scan_step = !prime_reg;
                cmd.push_en = 1'b1;
                cmd.next_i = !prime_reg && stat.scan_last && ret_reg == dc2d_pkg::ST_POP
                             && 1'b0;
            end
            dc2d_pkg::ST_POP: cmd.pop = !stat.q_empty;
            dc2d_pkg::ST_POP_WAIT: cmd.take_q = 1'b1;
            dc2d_pkg::ST_CNT_Q_END: cmd.seed_i = 1'b0;
            dc2d_pkg::ST_EMIT: begin
                if (!prime_reg && m_free) begin
                    cmd.emit_step = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    `DC_ASSERT_IMPL(a_no_load_busy, aclk, aresetn, state_reg != dc2d_pkg::ST_LOAD, !s_ready)
    `DC_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit_step, m_valid)
    `DC_ASSERT_IMPL(a_one_scan_cmd, aclk, aresetn, 1'b1, !(cmd.scan_start && cmd.scan_step))
endmodule

// ----- rtl/density_clustering_2d_core.sv -----
// top level of the 2d density clustering core
// depends on dc2d_pkg, dc2d_ctrl, dc2d_datapath
// Points are taken one per cycle until a request with final_point set; up to 64 are kept
// and further ones dropped. Clustering then runs in load order: every neighbor count and
// every queue push walks all N stored points through a three-stage distance pipeline.
// Then one label per point leaves in load order, up to one per cycle as m_ready allows,
// while no new point is accepted.
module density_clustering_2d_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  dc2d_pkg::in_item_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output dc2d_pkg::out_item_t       m_data,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [dc2d_pkg::CfgW-1:0] cfg_data
);
    logic [dc2d_pkg::EpsW-1:0] eps_reg;
    logic [dc2d_pkg::MinW-1:0] min_reg;
    dc2d_pkg::cmd_t  cmd;
    dc2d_pkg::stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= dc2d_pkg::EpsW'(100);
            min_reg <= dc2d_pkg::MinW'(4);
        end else if (cfg_we) begin
            case (cfg_index)
                dc2d_pkg::CfgEps: eps_reg <= cfg_data[dc2d_pkg::EpsW-1:0];
                dc2d_pkg::CfgMin: min_reg <= cfg_data[dc2d_pkg::MinW-1:0];
                default: ;
            endcase
        end
    end

    dc2d_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_final(s_data.final_point),
        .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd));

    dc2d_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .s_item(s_data),
        .eps_reg_in(eps_reg), .min_reg_in(min_reg), .m_item(m_data));
endmodule

// ----- dv/density_clustering_2d_core_chk.sv -----
// checker for the clustering core: watches both channels, predicts labels, compares
// depends on dc2d_pkg; instantiated by density_clustering_2d_core_tb
module density_clustering_2d_core_chk (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  dc2d_pkg::in_item_t        s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  dc2d_pkg::out_item_t       m_data,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [dc2d_pkg::CfgW-1:0] cfg_data,
    output int                        fail_count,
    output int                        labels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [dc2d_pkg::EpsW-1:0] eps_sq;
    logic [dc2d_pkg::MinW-1:0] min_pts;
    logic [15:0] xs [dc2d_pkg::MaxPoints];
    logic [15:0] ys [dc2d_pkg::MaxPoints];
    int n_pts;
    dc2d_pkg::out_item_t label_q [$];

    function automatic bit near(int p, int q);
        int dx, dy;
        longint d;
        dx = (xs[p] >= xs[q]) ? (xs[p] - xs[q]) : (xs[q] - xs[p]);
        dy = (ys[p] >= ys[q]) ? (ys[p] - ys[q]) : (ys[q] - ys[p]);
        dx = dx >> 4;
        dy = dy >> 4;
        d = longint'(dx) * dx + longint'(dy) * dy;
        return d != 0 && d <= eps_sq;
    endfunction

    function automatic int degree(int p);
        int c;
        c = 0;
        for (int q = 0; q < n_pts; q++) if (near(p, q)) c++;
        return c;
    endfunction

    task automatic cluster_set();
        bit seen [dc2d_pkg::MaxPoints];
        bit queued [dc2d_pkg::MaxPoints];
        logic [dc2d_pkg::LabelW-1:0] lab [dc2d_pkg::MaxPoints];
        int bfs [$];
        logic [dc2d_pkg::LabelW-1:0] cid;
        int q;
        dc2d_pkg::out_item_t r;
        cid = '0;
        for (int k = 0; k < dc2d_pkg::MaxPoints; k++) begin
            seen[k] = 0;
            queued[k] = 0;
            lab[k] = '0;
        end
        for (int i = 0; i < n_pts; i++) begin
            if (seen[i]) continue;
            seen[i] = 1;
            if (degree(i) < min_pts) continue;
            cid = cid + 1'b1;
            lab[i] = cid;
            queued[i] = 1;
            bfs.delete();
            for (int k = 0; k < n_pts; k++) begin
                if (near(i, k) && !queued[k]) begin
                    queued[k] = 1;
                    bfs = {bfs, k};
                end
            end
            while (bfs.size() > 0) begin
                q = bfs.pop_front();
                if (!seen[q]) begin
                    seen[q] = 1;
                    if (degree(q) >= min_pts) begin
                        for (int k = 0; k < n_pts; k++) begin
                            if (near(q, k) && !queued[k]) begin
                                queued[k] = 1;
                                bfs = {bfs, k};
                            end
                        end
                    end
                end
                if (lab[q] == 0) lab[q] = cid;
            end
        end
        for (int k = 0; k < n_pts; k++) begin
            r.point_index = k[dc2d_pkg::IdxW-1:0];
            r.cluster_label = lab[k];
            r.end_of_labels = (k + 1 == n_pts);
            label_q = {label_q, r};
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        dc2d_pkg::out_item_t e;
        if (!aresetn) begin
            eps_sq <= 26'd100;
            min_pts <= 7'd4;
            n_pts = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == dc2d_pkg::CfgEps) eps_sq <= cfg_data[dc2d_pkg::EpsW-1:0];
                else min_pts <= cfg_data[dc2d_pkg::MinW-1:0];
            end
            if (s_valid && s_ready) begin
                if (n_pts < dc2d_pkg::MaxPoints) begin
                    xs[n_pts] = s_data.pos_x;
                    ys[n_pts] = s_data.pos_y;
                    n_pts++;
                end
                if (s_data.final_point) begin
                    cluster_set();
                    n_pts = 0;
                end
            end
            if (m_valid && m_ready) begin
                if (label_q.size() == 0) begin
                    report("unexpected label", m_data.point_index, -1);
                end else begin
                    e = label_q.pop_front();
                    if (m_data.point_index !== e.point_index)
                        report("point_index", m_data.point_index, e.point_index);
                    if (m_data.cluster_label !== e.cluster_label)
                        report("cluster_label", m_data.cluster_label, e.cluster_label);
                    if (m_data.end_of_labels !== e.end_of_labels)
                        report("end_of_labels", m_data.end_of_labels, e.end_of_labels);
                end
            end
        end
        labels_pending = label_q.size();
    end
endmodule

// ----- dv/density_clustering_2d_core_tb.sv -----
// testbench top for the clustering core: clock, reset, point sets, config, verdict
// depends on dc2d_pkg, density_clustering_2d_core, density_clustering_2d_core_chk
module density_clustering_2d_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    dc2d_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    dc2d_pkg::out_item_t m_data;
    logic cfg_we = 0;
    logic cfg_index = dc2d_pkg::CfgEps;
    logic [dc2d_pkg::CfgW-1:0] cfg_data = '0;
    int fail_count;
    int labels_pending;
    longint cycles = 0;
    bit calm = 0;
    int points_sent = 0;

    always #5 aclk = ~aclk;

    density_clustering_2d_core DUT (.*);
    density_clustering_2d_core_chk checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("[density_clustering_2d_core] ERROR");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 17);
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    task automatic send_point(logic [15:0] x, logic [15:0] y, bit last);
        int n;
        if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 17);
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{pos_x: x, pos_y: y, final_point: last};
        do @(posedge aclk); while (!s_ready);
        points_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (labels_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [dc2d_pkg::CfgW-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // clustered set: a few blobs plus scattered noise
    task automatic send_blob_set(int n, int spread);
        int cx, cy;
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                cx = $urandom_range(0, 65535);
                cy = $urandom_range(0, 65535);
            end
            if ($urandom_range(0, 5) == 0)
                send_point(16'($urandom), 16'($urandom), k == n - 1);
            else
                send_point(16'((cx + $urandom_range(0, spread)) & 16'hffff),
                           16'((cy + $urandom_range(0, spread)) & 16'hffff), k == n - 1);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, coincident and sub-pixel points, self only set
        send_point(16'h0000, 16'h0000, 1);
        drain();
        send_point(16'h0000, 16'h0000, 0);
        send_point(16'h000f, 16'h000f, 0);
        send_point(16'hffff, 16'hffff, 0);
        send_point(16'hfff0, 16'hffff, 0);
        send_point(16'h0050, 16'h0000, 0);
        send_point(16'h00a0, 16'h0000, 0);
        send_point(16'h0000, 16'h00a0, 1);
        drain();
        write_reg(dc2d_pkg::CfgMin, dc2d_pkg::CfgW'(0));
        write_reg(dc2d_pkg::CfgEps, dc2d_pkg::CfgW'(0));
        send_point(16'h1234, 16'h4321, 0);
        send_point(16'h1244, 16'h4321, 0);
        send_point(16'haaaa, 16'h5555, 1);
        drain();
        write_reg(dc2d_pkg::CfgMin, dc2d_pkg::CfgW'(1));
        write_reg(dc2d_pkg::CfgEps, 26'h3ffffff);
        send_point(16'h0000, 16'hffff, 0);
        send_point(16'hffff, 16'h0000, 0);
        send_point(16'h8000, 16'h8000, 1);
        drain();
        write_reg(dc2d_pkg::CfgMin, dc2d_pkg::CfgW'(127));
        send_blob_set(6, 300);
        drain();
        // overflow: 70 points in one set
        write_reg(dc2d_pkg::CfgMin, dc2d_pkg::CfgW'(3));
        write_reg(dc2d_pkg::CfgEps, dc2d_pkg::CfgW'(400));
        send_blob_set(70, 400);
        drain();
        // random sets
        while (points_sent < 170) begin
            case ($urandom_range(0, 4))
                0: write_reg(dc2d_pkg::CfgEps, dc2d_pkg::CfgW'($urandom_range(0, 2000)));
                1: write_reg(dc2d_pkg::CfgMin, dc2d_pkg::CfgW'($urandom_range(0, 6)));
                2: write_reg(dc2d_pkg::CfgEps,
                             dc2d_pkg::CfgW'($urandom_range(0, 26'h3ffffff)));
                default: ;
            endcase
            if (points_sent > 140) calm = 1;
            send_blob_set($urandom_range(1, 14), $urandom_range(16, 1200));
            if ($urandom_range(0, 1) == 0) drain();
        end
        drain();
        if (fail_count == 0) begin
            $display("[density_clustering_2d_core] OK");
        end else begin
            $display("[density_clustering_2d_core] ERROR");
        end
        $finish;
    end
endmodule
